FILE: rtl/svgpn_pkg.sv
// Shared types and constants of the SVG path command normaliser.
package svgpn_pkg;

  localparam int ParamSlots = 10;
  localparam int MaxParams  = 7;
  localparam int MaxResults = 3;
  localparam int HeldW      = 4;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int RdW        = $clog2(MaxResults);

  typedef logic signed [31:0] q16_t;

  typedef enum logic [2:0] {
    KindMove  = 3'd0,
    KindLine  = 3'd1,
    KindCubic = 3'd2,
    KindQuad  = 3'd3,
    KindCont  = 3'd4,
    KindClose = 3'd5
  } kind_e;

  typedef struct packed {
    logic       is_command;
    logic [7:0] command_char;
    q16_t       number_value;
  } token_t;

  typedef struct packed {
    kind_e kind;
    q16_t  x;
    q16_t  y;
  } point_t;

  typedef struct packed {
    logic [CntW-1:0]              cnt;
    point_t [MaxResults-1:0]      pts;
  } res_t;

endpackage

FILE: rtl/svgpn_parser.sv
// Token parser: path state, parameter collection and point generation for one token.
module svgpn_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  svgpn_pkg::token_t     tok_i,
  output svgpn_pkg::res_t       res_o
);

  localparam int IdxW = $clog2(svgpn_pkg::ParamSlots);

  localparam logic [7:0] LetMu = "M";
  localparam logic [7:0] LetMl = "m";
  localparam logic [7:0] LetZu = "Z";
  localparam logic [7:0] LetZl = "z";
  localparam logic [7:0] LetLu = "L";
  localparam logic [7:0] LetLl = "l";
  localparam logic [7:0] LetHu = "H";
  localparam logic [7:0] LetHl = "h";
  localparam logic [7:0] LetVu = "V";
  localparam logic [7:0] LetVl = "v";
  localparam logic [7:0] LetAu = "A";
  localparam logic [7:0] LetAl = "a";
  localparam logic [7:0] LetCu = "C";
  localparam logic [7:0] LetCl = "c";
  localparam logic [7:0] LetSu = "S";
  localparam logic [7:0] LetSl = "s";
  localparam logic [7:0] LetQu = "Q";
  localparam logic [7:0] LetQl = "q";
  localparam logic [7:0] LetTu = "T";
  localparam logic [7:0] LetTl = "t";

  typedef enum logic [1:0] {
    PhSeek  = 2'd0,
    PhMoveX = 2'd1,
    PhMoveY = 2'd2,
    PhRun   = 2'd3
  } phase_e;

  function automatic svgpn_pkg::q16_t sat_add(svgpn_pkg::q16_t a, svgpn_pkg::q16_t b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  function automatic svgpn_pkg::q16_t reflect(svgpn_pkg::q16_t cur, svgpn_pkg::q16_t ctl);
    logic [33:0] t;
    t = {cur[31], cur, 1'b0} - {{2{ctl[31]}}, ctl};
    if ((t[33] != t[32]) || (t[32] != t[31])) begin
      reflect = t[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      reflect = t[31:0];
    end
  endfunction

  function automatic svgpn_pkg::q16_t to_abs(logic rel, svgpn_pkg::q16_t base,
                                             svgpn_pkg::q16_t p);
    to_abs = rel ? sat_add(base, p) : p;
  endfunction

  svgpn_pkg::q16_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  svgpn_pkg::q16_t ctl_x_q, ctl_x_d, ctl_y_q, ctl_y_d;
  svgpn_pkg::q16_t start_x_q, start_x_d, start_y_q, start_y_d;
  logic [7:0]                   active_q, active_d;
  logic [2:0]                   need_q, need_d;
  logic [svgpn_pkg::HeldW-1:0]  held_q, held_d;
  phase_e                       phase_q, phase_d;
  svgpn_pkg::q16_t              param_q [svgpn_pkg::ParamSlots];
  logic                         param_we;
  logic [IdxW-1:0]              param_wa;

  logic [IdxW-1:0]              idx;
  logic [svgpn_pkg::HeldW-1:0]  held_next;
  svgpn_pkg::q16_t              p [svgpn_pkg::MaxParams];
  logic                         rel;
  svgpn_pkg::q16_t              ax0, ay0, ax1, ay1, ax2, ay2, axa, aya, ayv;
  svgpn_pkg::q16_t              rx, ry, mvx, mvy;
  svgpn_pkg::token_t            tok;

  assign tok = tok_i;

  always_comb begin
    if (held_q >= svgpn_pkg::HeldW'(svgpn_pkg::ParamSlots - 1)) begin
      idx = IdxW'(svgpn_pkg::ParamSlots - 1);
    end else begin
      idx = IdxW'(held_q);
    end
    held_next = svgpn_pkg::HeldW'(idx) + svgpn_pkg::HeldW'(1);
  end

  always_comb begin
    for (int i = 0; i < svgpn_pkg::MaxParams; i++) begin
      p[i] = (idx == IdxW'(i)) ? tok.number_value : param_q[i];
    end
  end

  always_comb begin
    case (active_q) inside
      ["a":"z"]: rel = 1'b1;
      default:   rel = 1'b0;
    endcase
  end

  assign ax0 = to_abs(rel, cur_x_q, p[0]);
  assign ay0 = to_abs(rel, cur_y_q, p[1]);
  assign ax1 = to_abs(rel, cur_x_q, p[2]);
  assign ay1 = to_abs(rel, cur_y_q, p[3]);
  assign ax2 = to_abs(rel, cur_x_q, p[4]);
  assign ay2 = to_abs(rel, cur_y_q, p[5]);
  assign axa = to_abs(rel, cur_x_q, p[5]);
  assign aya = to_abs(rel, cur_y_q, p[6]);
  assign ayv = to_abs(rel, cur_y_q, p[0]);
  assign rx  = reflect(cur_x_q, ctl_x_q);
  assign ry  = reflect(cur_y_q, ctl_y_q);
  assign mvx = (active_q == LetMu) ? param_q[0] : sat_add(cur_x_q, param_q[0]);
  assign mvy = (active_q == LetMu) ? tok.number_value : sat_add(cur_y_q, tok.number_value);

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    ctl_x_d   = ctl_x_q;
    ctl_y_d   = ctl_y_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    active_d  = active_q;
    need_d    = need_q;
    held_d    = held_q;
    phase_d   = phase_q;
    param_we  = 1'b0;
    param_wa  = idx;
    res_o     = '0;

    case (phase_q)
      PhSeek: begin
        if (tok.is_command) begin
          if ((tok.command_char == LetMu) || (tok.command_char == LetMl)) begin
            active_d = tok.command_char;
            phase_d  = PhMoveX;
          end
        end
      end
      PhMoveX, PhMoveY: begin
        if (tok.is_command) begin
          if ((tok.command_char == LetMu) || (tok.command_char == LetMl)) begin
            active_d = tok.command_char;
            phase_d  = PhMoveX;
          end else begin
            phase_d = PhSeek;
          end
        end else if (phase_q == PhMoveX) begin
          param_we = 1'b1;
          param_wa = '0;
          phase_d  = PhMoveY;
        end else begin
          param_we  = 1'b1;
          param_wa  = IdxW'(1);
          cur_x_d   = mvx;
          cur_y_d   = mvy;
          ctl_x_d   = mvx;
          ctl_y_d   = mvy;
          start_x_d = mvx;
          start_y_d = mvy;
          active_d  = (active_q == LetMu) ? LetLu : LetLl;
          need_d    = 3'd2;
          held_d    = '0;
          phase_d   = PhRun;
          res_o.cnt = svgpn_pkg::CntW'(1);
          res_o.pts[0] = '{kind: svgpn_pkg::KindMove, x: mvx, y: mvy};
        end
      end
      default: begin
        if (tok.is_command) begin
          held_d = '0;
          case (tok.command_char)
            LetMu, LetMl: begin
              active_d = tok.command_char;
              phase_d  = PhMoveX;
            end
            LetZu, LetZl: begin
              cur_x_d   = start_x_q;
              cur_y_d   = start_y_q;
              ctl_x_d   = start_x_q;
              ctl_y_d   = start_y_q;
              phase_d   = PhSeek;
              res_o.cnt = svgpn_pkg::CntW'(1);
              res_o.pts[0] = '{kind: svgpn_pkg::KindClose, x: start_x_q, y: start_y_q};
            end
            default: begin
              active_d = tok.command_char;
              case (tok.command_char)
                LetVu, LetVl, LetHu, LetHl: need_d = 3'd1;
                LetSu, LetSl, LetQu, LetQl: need_d = 3'd4;
                LetCu, LetCl:               need_d = 3'd6;
                LetAu, LetAl:               need_d = 3'd7;
                default:                    need_d = 3'd2;
              endcase
            end
          endcase
        end else begin
          param_we = 1'b1;
          held_d   = held_next;
          if (held_next >= svgpn_pkg::HeldW'(need_q)) begin
            held_d = '0;
            case (active_q)
              LetLu, LetLl, LetHu, LetHl, LetVu, LetVl, LetAu, LetAl: begin
                case (active_q)
                  LetLu, LetLl: begin
                    cur_x_d = ax0;
                    cur_y_d = ay0;
                  end
                  LetHu, LetHl: begin
                    cur_x_d = ax0;
                    cur_y_d = cur_y_q;
                  end
                  LetVu, LetVl: begin
                    cur_x_d = cur_x_q;
                    cur_y_d = ayv;
                  end
                  default: begin
                    cur_x_d = axa;
                    cur_y_d = aya;
                  end
                endcase
                ctl_x_d   = cur_x_d;
                ctl_y_d   = cur_y_d;
                res_o.cnt = svgpn_pkg::CntW'(1);
                res_o.pts[0] = '{kind: svgpn_pkg::KindLine, x: cur_x_d, y: cur_y_d};
              end
              LetCu, LetCl: begin
                ctl_x_d   = ax1;
                ctl_y_d   = ay1;
                cur_x_d   = ax2;
                cur_y_d   = ay2;
                res_o.cnt = svgpn_pkg::CntW'(3);
                res_o.pts[0] = '{kind: svgpn_pkg::KindCubic, x: ax0, y: ay0};
                res_o.pts[1] = '{kind: svgpn_pkg::KindCont, x: ax1, y: ay1};
                res_o.pts[2] = '{kind: svgpn_pkg::KindCont, x: ax2, y: ay2};
              end
              LetSu, LetSl: begin
                ctl_x_d   = ax0;
                ctl_y_d   = ay0;
                cur_x_d   = ax1;
                cur_y_d   = ay1;
                res_o.cnt = svgpn_pkg::CntW'(3);
                res_o.pts[0] = '{kind: svgpn_pkg::KindCubic, x: rx, y: ry};
                res_o.pts[1] = '{kind: svgpn_pkg::KindCont, x: ax0, y: ay0};
                res_o.pts[2] = '{kind: svgpn_pkg::KindCont, x: ax1, y: ay1};
              end
              LetQu, LetQl: begin
                ctl_x_d   = ax0;
                ctl_y_d   = ay0;
                cur_x_d   = ax1;
                cur_y_d   = ay1;
                res_o.cnt = svgpn_pkg::CntW'(2);
                res_o.pts[0] = '{kind: svgpn_pkg::KindQuad, x: ax0, y: ay0};
                res_o.pts[1] = '{kind: svgpn_pkg::KindCont, x: ax1, y: ay1};
              end
              LetTu, LetTl: begin
                ctl_x_d   = rx;
                ctl_y_d   = ry;
                cur_x_d   = ax0;
                cur_y_d   = ay0;
                res_o.cnt = svgpn_pkg::CntW'(2);
                res_o.pts[0] = '{kind: svgpn_pkg::KindQuad, x: rx, y: ry};
                res_o.pts[1] = '{kind: svgpn_pkg::KindCont, x: ax0, y: ay0};
              end
              default: begin
                held_d = '0;
              end
            endcase
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      ctl_x_q   <= '0;
      ctl_y_q   <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      active_q  <= '0;
      need_q    <= 3'd2;
      held_q    <= '0;
      phase_q   <= PhSeek;
    end else if (step_i) begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      ctl_x_q   <= ctl_x_d;
      ctl_y_q   <= ctl_y_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      active_q  <= active_d;
      need_q    <= need_d;
      held_q    <= held_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && param_we) begin
      param_q[param_wa] <= tok.number_value;
    end
  end

endmodule

FILE: rtl/svg_path_command_normalizer.sv
// Top level of the SVG path command normaliser: input register, parser and result buffer.
//
// The slave channel takes one path token per transfer: tuser says whether the
// token is a command letter or a Q16.16 number, and tdata carries both values.
// The master channel gives one point per transfer: tuser holds the point kind,
// tdata the absolute x and y, and tlast marks the final point caused by a token.
// A token is held in an input register and is processed once the result buffer can
// take it, when its points (none to three) are loaded into the three-entry result buffer.
// The points of a token are offered from that registered result buffer.
// Tokens are taken at one per cycle as long as each yields at most one point
// and the receiver keeps tready high; a token with several points holds the
// result buffer until all of them are taken, so a cubic curve holds it for three points.
// The input register is still free to take the next token while points wait.
// When the receiver stalls, the buffered points hold and tokens back up into
// the input register, after which tready drops.
// Reset clears the path state to the origin, seeks a move command, and empties
// both the input register and the result buffer.
module svg_path_command_normalizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // command_char [7:0], number_value [39:8]
  input  logic        s_axis_tuser_i,   // is_command [0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // point_x [31:0], point_y [63:32]
  output logic [2:0]  m_axis_tuser_o,   // point_kind [2:0]
  output logic        m_axis_tlast_o
);

  logic                           in_valid_q, in_valid_d;
  svgpn_pkg::token_t              in_tok_q;
  logic                           buf_free;
  logic                           step;
  logic                           s_fire, m_fire;
  svgpn_pkg::res_t                res;
  svgpn_pkg::point_t              buf_q [svgpn_pkg::MaxResults];
  logic [svgpn_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [svgpn_pkg::RdW-1:0]      rd_q, rd_d;
  svgpn_pkg::point_t              head;

  assign m_fire   = m_axis_tvalid_o && m_axis_tready_i;
  assign buf_free = (cnt_q == '0) || ((cnt_q == svgpn_pkg::CntW'(1)) && m_axis_tready_i);
  assign step     = in_valid_q && buf_free;
  assign s_axis_tready_o = !in_valid_q || step;
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;

  svgpn_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .tok_i  (in_tok_q),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (step) begin
      cnt_d = res.cnt;
      rd_d  = '0;
    end else if (m_fire) begin
      cnt_d = cnt_q - svgpn_pkg::CntW'(1);
      rd_d  = rd_q + svgpn_pkg::RdW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= '0;
      rd_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      cnt_q      <= cnt_d;
      rd_q       <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_tok_q <= '{is_command:   s_axis_tuser_i,
                    command_char: s_axis_tdata_i[7:0],
                    number_value: s_axis_tdata_i[39:8]};
    end
    if (step) begin
      for (int i = 0; i < svgpn_pkg::MaxResults; i++) begin
        buf_q[i] <= res.pts[i];
      end
    end
  end

  assign head            = buf_q[rd_q];
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {head.y, head.x};
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = (cnt_q == svgpn_pkg::CntW'(1));

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (res.cnt != '0) |=> m_axis_tvalid_o)
    else $error("Points loaded into the result buffer were not offered.");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rd_q} + {1'b0, cnt_q}) <= 3'(svgpn_pkg::MaxResults))
    else $error("Result buffer read position ran past the stored points.");

  a_block_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !buf_free |-> !s_axis_tready_o)
    else $error("A token was taken while the input register could not drain.");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && m_axis_tlast_o && !step |=> !m_axis_tvalid_o)
    else $error("Points remained after the final point of a token was taken.");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench of the SVG path command normaliser with random stream stalls.
`timescale 1ns / 1ps

module testbench;

  localparam int TokenTarget   = 215;
  localparam int HoldOffAt     = 120;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 16;
  localparam int WatchLimit    = 3000;

  localparam logic [7:0] CaseMask      = 8'hDF;
  localparam logic [7:0] RelBit        = 8'h20;
  localparam logic [7:0] CmdMove       = "M";
  localparam logic [7:0] CmdLine       = "L";
  localparam logic [7:0] CmdHoriz      = "H";
  localparam logic [7:0] CmdVert       = "V";
  localparam logic [7:0] CmdCubic      = "C";
  localparam logic [7:0] CmdSmooth     = "S";
  localparam logic [7:0] CmdQuad       = "Q";
  localparam logic [7:0] CmdSmoothQuad = "T";
  localparam logic [7:0] CmdArc        = "A";
  localparam logic [7:0] CmdClose      = "Z";
  localparam logic [7:0] CmdUnknown    = 8'hFF;
  localparam logic [7:0] CharNull      = 8'h00;

  localparam svgpn_pkg::q16_t QMax = 32'sh7FFF_FFFF;
  localparam svgpn_pkg::q16_t QMin = 32'sh8000_0000;

  typedef enum logic [1:0] {PsSeek, PsMoveX, PsMoveY, PsRun} parse_state_e;
  typedef enum logic [1:0] {RxFree, RxHalf, RxSparse, RxMostly} rx_mode_e;

  typedef struct {
    svgpn_pkg::kind_e kind;
    svgpn_pkg::q16_t  x;
    svgpn_pkg::q16_t  y;
    logic             last;
  } path_point_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  svgpn_pkg::token_t pending_tokens[$];
  path_point_t       expected_points[$];
  int                mismatch_count = 0;
  int                tokens_taken   = 0;

  // Path state of the prediction.
  svgpn_pkg::q16_t cur_x = '0, cur_y = '0, ctl_x = '0, ctl_y = '0, sub_x = '0, sub_y = '0;
  logic [7:0]      path_letter   = '0;
  int unsigned     params_wanted = 2;
  int unsigned     params_held   = 0;
  svgpn_pkg::q16_t param_buf[svgpn_pkg::ParamSlots];
  parse_state_e    parse_state   = PsSeek;

  svg_path_command_normalizer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #2 clk_i = ~clk_i;

  function automatic svgpn_pkg::q16_t clamp_q16(longint v);
    if (v > longint'(QMax)) return QMax;
    if (v < longint'(QMin)) return QMin;
    return svgpn_pkg::q16_t'(v);
  endfunction

  function automatic svgpn_pkg::q16_t add_sat(svgpn_pkg::q16_t a, svgpn_pkg::q16_t b);
    return clamp_q16(longint'(a) + longint'(b));
  endfunction

  function automatic svgpn_pkg::q16_t mirror(svgpn_pkg::q16_t cur, svgpn_pkg::q16_t ctl);
    return clamp_q16(2 * longint'(cur) - longint'(ctl));
  endfunction

  function automatic int unsigned params_for(logic [7:0] c);
    case (c & CaseMask)
      CmdHoriz, CmdVert:      return 1;
      CmdLine, CmdSmoothQuad: return 2;
      CmdSmooth, CmdQuad:     return 4;
      CmdCubic:               return 6;
      CmdArc:                 return 7;
      default:                return 2;
    endcase
  endfunction

  function automatic void add_point(svgpn_pkg::kind_e k, svgpn_pkg::q16_t x,
                                    svgpn_pkg::q16_t y);
    path_point_t p;
    p.kind = k;
    p.x    = x;
    p.y    = y;
    p.last = 1'b0;
    expected_points.push_back(p);
  endfunction

  function automatic void line_to(svgpn_pkg::q16_t x, svgpn_pkg::q16_t y);
    cur_x = x;
    cur_y = y;
    ctl_x = x;
    ctl_y = y;
    add_point(svgpn_pkg::KindLine, x, y);
  endfunction

  function automatic void seek_move(logic [7:0] c);
    if ((c & CaseMask) == CmdMove) begin
      path_letter = c;
      parse_state = PsMoveX;
    end else begin
      parse_state = PsSeek;
    end
  endfunction

  function automatic void draw_segment();
    svgpn_pkg::q16_t bx;
    svgpn_pkg::q16_t by;
    bx = (path_letter & RelBit) != 0 ? cur_x : '0;
    by = (path_letter & RelBit) != 0 ? cur_y : '0;
    case (path_letter & CaseMask)
      CmdLine:  line_to(add_sat(bx, param_buf[0]), add_sat(by, param_buf[1]));
      CmdHoriz: line_to(add_sat(bx, param_buf[0]), cur_y);
      CmdVert:  line_to(cur_x, add_sat(by, param_buf[0]));
      CmdArc:   line_to(add_sat(bx, param_buf[5]), add_sat(by, param_buf[6]));
      CmdCubic: begin
        for (int i = 0; i < 6; i++) param_buf[i] = add_sat((i % 2) ? by : bx, param_buf[i]);
        add_point(svgpn_pkg::KindCubic, param_buf[0], param_buf[1]);
        add_point(svgpn_pkg::KindCont, param_buf[2], param_buf[3]);
        add_point(svgpn_pkg::KindCont, param_buf[4], param_buf[5]);
        ctl_x = param_buf[2];
        ctl_y = param_buf[3];
        cur_x = param_buf[4];
        cur_y = param_buf[5];
      end
      CmdSmooth: begin
        for (int i = 0; i < 4; i++) param_buf[i] = add_sat((i % 2) ? by : bx, param_buf[i]);
        add_point(svgpn_pkg::KindCubic, mirror(cur_x, ctl_x), mirror(cur_y, ctl_y));
        add_point(svgpn_pkg::KindCont, param_buf[0], param_buf[1]);
        add_point(svgpn_pkg::KindCont, param_buf[2], param_buf[3]);
        ctl_x = param_buf[0];
        ctl_y = param_buf[1];
        cur_x = param_buf[2];
        cur_y = param_buf[3];
      end
      CmdQuad: begin
        for (int i = 0; i < 4; i++) param_buf[i] = add_sat((i % 2) ? by : bx, param_buf[i]);
        add_point(svgpn_pkg::KindQuad, param_buf[0], param_buf[1]);
        add_point(svgpn_pkg::KindCont, param_buf[2], param_buf[3]);
        ctl_x = param_buf[0];
        ctl_y = param_buf[1];
        cur_x = param_buf[2];
        cur_y = param_buf[3];
      end
      CmdSmoothQuad: begin
        param_buf[0] = add_sat(bx, param_buf[0]);
        param_buf[1] = add_sat(by, param_buf[1]);
        ctl_x = mirror(cur_x, ctl_x);
        ctl_y = mirror(cur_y, ctl_y);
        add_point(svgpn_pkg::KindQuad, ctl_x, ctl_y);
        add_point(svgpn_pkg::KindCont, param_buf[0], param_buf[1]);
        cur_x = param_buf[0];
        cur_y = param_buf[1];
      end
      default: ;
    endcase
  endfunction

  function automatic void track_token(logic is_cmd, logic [7:0] c, svgpn_pkg::q16_t v);
    int          queued_before;
    int unsigned slot;
    queued_before = expected_points.size();
    case (parse_state)
      PsSeek: if (is_cmd) seek_move(c);
      PsMoveX: begin
        if (is_cmd) begin
          seek_move(c);
        end else begin
          param_buf[0] = v;
          parse_state  = PsMoveY;
        end
      end
      PsMoveY: begin
        if (is_cmd) begin
          seek_move(c);
        end else begin
          param_buf[1] = v;
          if (path_letter == CmdMove) begin
            cur_x       = param_buf[0];
            cur_y       = param_buf[1];
            path_letter = CmdLine;
          end else begin
            cur_x       = add_sat(cur_x, param_buf[0]);
            cur_y       = add_sat(cur_y, param_buf[1]);
            path_letter = CmdLine | RelBit;
          end
          ctl_x         = cur_x;
          sub_x         = cur_x;
          ctl_y         = cur_y;
          sub_y         = cur_y;
          params_wanted = 2;
          params_held   = 0;
          parse_state   = PsRun;
          add_point(svgpn_pkg::KindMove, cur_x, cur_y);
        end
      end
      default: begin
        if (is_cmd) begin
          params_held = 0;
          if ((c & CaseMask) == CmdMove) begin
            seek_move(c);
          end else if ((c & CaseMask) == CmdClose) begin
            cur_x       = sub_x;
            ctl_x       = sub_x;
            cur_y       = sub_y;
            ctl_y       = sub_y;
            parse_state = PsSeek;
            add_point(svgpn_pkg::KindClose, sub_x, sub_y);
          end else begin
            path_letter   = c;
            params_wanted = params_for(c);
          end
        end else begin
          slot = (params_held >= svgpn_pkg::ParamSlots) ? svgpn_pkg::ParamSlots - 1
                                                        : params_held;
          param_buf[slot] = v;
          params_held = (slot + 1) & 15;
          if (params_held >= params_wanted) begin
            draw_segment();
            params_held = 0;
          end
        end
      end
    endcase
    if (expected_points.size() > queued_before)
      expected_points[expected_points.size() - 1].last = 1'b1;
  endfunction

  function automatic void push_letter(logic [7:0] c);
    svgpn_pkg::token_t t;
    t.is_command   = 1'b1;
    t.command_char = c;
    t.number_value = svgpn_pkg::q16_t'($urandom);
    pending_tokens.push_back(t);
  endfunction

  function automatic void push_number(svgpn_pkg::q16_t v);
    svgpn_pkg::token_t t;
    t.is_command   = 1'b0;
    t.command_char = 8'($urandom_range(0, 255));
    t.number_value = v;
    pending_tokens.push_back(t);
  endfunction

  function automatic svgpn_pkg::q16_t random_coord();
    case ($urandom_range(0, 15))
      0:       return svgpn_pkg::q16_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return QMax;
          1:       return QMin;
          2:       return '0;
          default: return -32'sd1;
        endcase
      end
      default: return svgpn_pkg::q16_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [7:0] either_case(logic [7:0] c);
    return $urandom_range(0, 1) ? (c | RelBit) : c;
  endfunction

  function automatic logic [7:0] random_draw_letter();
    case ($urandom_range(0, 7))
      0:       return CmdLine;
      1:       return CmdHoriz;
      2:       return CmdVert;
      3:       return CmdCubic;
      4:       return CmdSmooth;
      5:       return CmdQuad;
      6:       return CmdSmoothQuad;
      default: return CmdArc;
    endcase
  endfunction

  // Token source: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    svgpn_pkg::token_t tok_out;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        track_token(s_tuser, s_tdata[7:0], svgpn_pkg::q16_t'(s_tdata[39:8]));
        tokens_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0 || pending_tokens.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          tok_out = pending_tokens.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= tok_out.is_command;
          s_tdata  <= {tok_out.number_value, tok_out.command_char};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Point sink: stall pattern changes mode now and then; one long hold-off.
  rx_mode_e    rx_mode   = RxFree;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic        held_off  = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!held_off && tokens_taken >= HoldOffAt) begin
        hold_left = HoldOffCycles;
        held_off  = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RxFree:   m_tready <= 1'b1;
          RxHalf:   m_tready <= 1'($urandom_range(0, 1));
          RxSparse: m_tready <= ($urandom_range(0, 3) == 0);
          default:  m_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    path_point_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point: kind %0d x %0d y %0d", m_tuser,
               $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
        mismatch_count++;
      end else begin
        want = expected_points.pop_front();
        if (m_tuser !== want.kind) begin
          $error("point_kind: expected %0d, got %0d", want.kind, m_tuser);
          mismatch_count++;
        end
        if (m_tdata[31:0] !== want.x) begin
          $error("point_x: expected %0d, got %0d", want.x, $signed(m_tdata[31:0]));
          mismatch_count++;
        end
        if (m_tdata[63:32] !== want.y) begin
          $error("point_y: expected %0d, got %0d", want.y, $signed(m_tdata[63:32]));
          mismatch_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
          mismatch_count++;
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned segments;
    int unsigned repeats;
    int unsigned count;
    int unsigned noise;
    logic [7:0]  letter;

    // Directed part: stray tokens while seeking, saturating line and
    // reflection, an unknown letter, close, and an abandoned relative move.
    push_number(QMax);
    push_letter(CharNull);
    push_letter(CmdMove);
    push_number(32'sh7FFF_0000);
    push_number(QMin);
    push_letter(CmdLine | RelBit);
    push_number(QMax);
    push_number(QMin);
    push_letter(CmdQuad);
    push_number(QMin);
    push_number(QMax);
    push_number(QMax);
    push_number(QMin);
    push_letter(CmdSmoothQuad);
    push_number('0);
    push_number('0);
    push_letter(CmdUnknown);
    push_number(32'sh0001_0000);
    push_number(-32'sd1);
    push_letter(CmdClose | RelBit);
    push_letter(CmdMove | RelBit);
    push_number(32'sh0001_0000);
    push_letter(CmdArc | RelBit);
    push_letter(CmdMove | RelBit);
    push_number(32'sh0002_8000);
    push_number(-32'sh0003_0000);

    // Random subpaths: mostly well formed, with noise and broken sequences.
    while (pending_tokens.size() < TokenTarget) begin
      if ($urandom_range(0, 9) == 0) begin
        noise = $urandom_range(1, 3);
        repeat (noise) begin
          if ($urandom_range(0, 1)) push_letter(8'($urandom_range(0, 255)));
          else push_number(svgpn_pkg::q16_t'($urandom));
        end
      end
      push_letter(either_case(CmdMove));
      if ($urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1)) push_number(random_coord());
        push_letter(either_case(random_draw_letter()));
        continue;
      end
      push_number(random_coord());
      push_number(random_coord());
      segments = $urandom_range(1, 6);
      repeat (segments) begin
        if ($urandom_range(0, 15) == 0) letter = 8'($urandom_range(0, 255));
        else letter = either_case(random_draw_letter());
        push_letter(letter);
        repeats = $urandom_range(1, 3);
        repeat (repeats) begin
          count = params_for(letter);
          if ($urandom_range(0, 11) == 0) count = $urandom_range(0, count + 1);
          repeat (count) push_number(random_coord());
        end
      end
      if ($urandom_range(0, 1)) push_letter(either_case(CmdClose));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_tokens.size() != 0 || s_tvalid || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_points.size() != 0) begin
      $error("%0d expected points never arrived", expected_points.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: sim.f
rtl/svgpn_pkg.sv
rtl/svgpn_parser.sv
rtl/svg_path_command_normalizer.sv
verif/testbench.sv
